// ----- rtl/spq_pkg.sv -----
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int PRIO_W       = 16;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    // one command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   del;
        logic   clr;
        t_entry item;
    } t_cmd;

    typedef struct packed {
        t_status                 status;
        logic signed [KEY_W-1:0] removed_key;
        logic [OCC_W-1:0]        occupancy;
    } t_result;

endpackage

// ----- rtl/spq_cell.sv -----
module spq_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spq_pkg::t_cmd   i_cmd,
    input  spq_pkg::t_entry i_left,
    input  logic            i_left_valid,
    input  logic            i_left_shift,
    input  spq_pkg::t_entry i_right,
    input  logic            i_right_valid,
    output spq_pkg::t_entry o_entry,
    output logic            o_valid,
    output logic            o_shift
);

    spq_pkg::t_entry r_entry;
    logic            r_valid;
    logic            w_after;

    // head: new item goes first only on strictly smaller priority
    always_comb begin
        if (IS_HEAD) begin
            w_after = i_cmd.item.prio < r_entry.prio;
        end else begin
            w_after = r_entry.prio >= i_cmd.item.prio;
        end
    end

    assign o_shift = !r_valid || w_after;
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clr) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ins && o_shift) begin
            r_valid <= i_left_shift ? i_left_valid : 1'b1;
        end else if (i_cmd.del) begin
            r_valid <= i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && o_shift) begin
            r_entry <= i_left_shift ? i_left : i_cmd.item;
        end else if (i_cmd.del) begin
            r_entry <= i_right;
        end
    end

endmodule

// ----- rtl/spq_out_buf.sv -----
module spq_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  spq_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output spq_pkg::t_result o_data
);

    spq_pkg::t_result r_slot0;
    spq_pkg::t_result r_slot1;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             w_pop;

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_data  = r_slot0;
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && r_cnt == 2'd2) begin
            r_slot0 <= r_slot1;
        end else if (i_push && (r_cnt == 2'd0 || (w_pop && r_cnt == 2'd1))) begin
            r_slot0 <= i_data;
        end
        if (i_push && ((r_cnt == 2'd1 && !w_pop) || (r_cnt == 2'd2 && w_pop))) begin
            r_slot1 <= i_data;
        end
    end

endmodule

// ----- rtl/sorted_priority_queue_core.sv -----
// Sorted priority queue, ascending by signed Q8.8 priority, at most CAPACITY entries.
// Input channel: i_in_valid / o_in_stall with i_kind, i_item_key, i_item_priority.
//   kind insert places the item after entries of smaller priority (ties with the
//   head land right behind it), delete removes the head, clear empties the queue.
// Output channel: o_out_valid / i_out_stall with o_status, o_removed_key,
//   o_occupancy; exactly one result per accepted item, in order.
// Each result is registered in the output buffer when its item is accepted.
// Throughput: one item per cycle while o_in_stall is low. The queue is a row of cells
//   that all update in the cycle an item is accepted; each cell compares its priority
//   with the new one and holds or takes the new item, its left or its right neighbor.
// Results wait in a two-deep output buffer; o_in_stall rises only while both
//   slots are occupied, so a stalled receiver blocks input after two results.
// Reset (synchronous, active low) empties the queue and the output buffer;
//   the block takes items as soon as reset is released.
// Occupancy is reported modulo 32.
module sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [spq_pkg::KIND_W-1:0]            i_kind,
    input  logic signed [spq_pkg::KEY_W-1:0]      i_item_key,
    input  logic signed [spq_pkg::PRIO_W-1:0]     i_item_priority,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [spq_pkg::STATUS_W-1:0]          o_status,
    output logic signed [spq_pkg::KEY_W-1:0]      o_removed_key,
    output logic [spq_pkg::OCC_W-1:0]             o_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                    w_acc;
    logic                    w_full;
    logic                    w_empty;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [CW+spq_pkg::OCC_W-1:0] w_count_ext;
    spq_pkg::t_cmd           w_cmd;
    spq_pkg::t_result        w_res;
    spq_pkg::t_result        w_out;
    logic                    w_buf_full;
    spq_pkg::t_entry         w_entry [CAPACITY];
    logic [CAPACITY-1:0]     w_valid;
    logic [CAPACITY-1:0]     w_shift;

    assign o_in_stall = w_buf_full;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_full     = r_count == CW'(CAPACITY);
    assign w_empty    = r_count == '0;

    always_comb begin
        w_cmd.ins       = 1'b0;
        w_cmd.del       = 1'b0;
        w_cmd.clr       = 1'b0;
        w_cmd.item.key  = i_item_key;
        w_cmd.item.prio = i_item_priority;
        w_res.status    = spq_pkg::ST_OK;
        n_count         = r_count;
        unique case (spq_pkg::t_kind'(i_kind))
            spq_pkg::KIND_INSERT: begin
                if (w_full) begin
                    w_res.status = spq_pkg::ST_FULL;
                end else begin
                    w_cmd.ins = w_acc;
                    n_count   = r_count + CW'(1);
                end
            end
            spq_pkg::KIND_DELETE: begin
                if (w_empty) begin
                    w_res.status = spq_pkg::ST_EMPTY;
                end else begin
                    w_cmd.del = w_acc;
                    n_count   = r_count - CW'(1);
                end
            end
            spq_pkg::KIND_CLEAR: begin
                w_cmd.clr = w_acc;
                n_count   = '0;
            end
            default: begin
            end
        endcase
        w_count_ext       = {{spq_pkg::OCC_W{1'b0}}, n_count};
        w_res.occupancy   = w_count_ext[spq_pkg::OCC_W-1:0];
        w_res.removed_key = w_cmd.del ? w_entry[0].key : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;
        logic            w_left_valid;
        logic            w_left_shift;
        logic            w_right_valid;

        if (g == 0) begin : g_first
            assign w_left       = '0;
            assign w_left_valid = 1'b0;
            assign w_left_shift = 1'b0;
        end else begin : g_mid
            assign w_left       = w_entry[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_shift = w_shift[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right       = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right       = w_entry[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        spq_cell #(
            .IS_HEAD (g == 0)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_left        (w_left),
            .i_left_valid  (w_left_valid),
            .i_left_shift  (w_left_shift),
            .i_right       (w_right),
            .i_right_valid (w_right_valid),
            .o_entry       (w_entry[g]),
            .o_valid       (w_valid[g]),
            .o_shift       (w_shift[g])
        );
    end

    spq_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc),
        .i_data  (w_res),
        .o_full  (w_buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_status      = w_out.status;
    assign o_removed_key = w_out.removed_key;
    assign o_occupancy   = w_out.occupancy;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with entry count");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valid + 1'b1 & ~w_valid) && ((w_valid & (w_valid + 1'b1)) == '0))
        else $error("valid cells are not a prefix");

    a_delete_head_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.del && w_valid[1] |=> w_entry[0] == $past(w_entry[1]))
        else $error("delete did not advance the second entry to the head");

endmodule
